/* hw/rtl/bgs_pkg.sv */
// Shared types, codes and helpers for the Burgers Godunov stencil block.
`default_nettype none

package bgs_pkg;

  localparam int CELL_BITS      = 32;
  localparam int DEF_MAX_CELLS  = 256;
  localparam int DEF_VALUE_BITS = 32;

  // Multiplier operand and product widths
  localparam int OPA_BITS  = 35;
  localparam int OPB_BITS  = 33;
  localparam int PROD_BITS = 64;

  // Item function codes
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_STEP  = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // Config register indexes
  localparam logic [1:0] CFG_CELL_COUNT = 2'd0;
  localparam logic [1:0] CFG_COURANT    = 2'd1;
  localparam logic [1:0] CFG_DIFFUSION  = 2'd2;

  localparam logic [8:0]  RST_CELL_COUNT = 9'd256;
  localparam logic [23:0] RST_COURANT    = 24'd6554;
  localparam logic [23:0] RST_DIFFUSION  = 24'd0;

  // Shared multiplier operations
  localparam logic [1:0] ALU_NONE = 2'd0;
  localparam logic [1:0] ALU_SQ   = 2'd1;
  localparam logic [1:0] ALU_DIFF = 2'd2;
  localparam logic [1:0] ALU_CONV = 2'd3;

  typedef struct packed {
    logic [1:0] op;
  } alu_ctrl_t;

  typedef struct packed {
    logic signed [PROD_BITS-1:0] prod;
    logic                        zero;
  } alu_stat_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [7:0]         cell_index;
    logic signed [31:0] cell_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic               index_error;
    logic               saturated;
  } out_t;

  // Q32.32 product back to Q16.16, round half up
  function automatic logic signed [PROD_BITS-1:0] round_q16(
    input logic signed [PROD_BITS-1:0] x
  );
    return (x + 64'sd32768) >>> 16;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/bgs_cell_ram.sv */
// Cell storage: one write port, one read port with registered data.
`default_nettype none

module bgs_cell_ram
  import bgs_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_CELLS,
  parameter int AW    = $clog2(DEF_MAX_CELLS)
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [CELL_BITS-1:0] wdata,
  input  wire logic [AW-1:0]        raddr,
  output logic      [CELL_BITS-1:0] rdata
);

  logic [CELL_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/bgs_alu.sv */
// Shared multiplier: flux square, diffusion and convection products.
`default_nettype none

module bgs_alu
  import bgs_pkg::*;
(
  input  wire logic               clk,
  input  wire alu_ctrl_t          ctrl,
  input  wire logic signed [31:0] fa,
  input  wire logic signed [31:0] fb,
  input  wire logic signed [31:0] cur,
  input  wire logic signed [31:0] right,
  input  wire logic signed [31:0] prev_old,
  input  wire logic signed [31:0] flux,
  input  wire logic signed [31:0] prev_flux,
  input  wire logic [23:0]        courant,
  input  wire logic [23:0]        diffusion,
  output alu_stat_t               stat
);

  logic signed [OPA_BITS-1:0]           op_a;
  logic signed [OPB_BITS-1:0]           op_b;
  logic signed [OPA_BITS+OPB_BITS-1:0]  mul;
  logic signed [32:0]                   pair_sum;
  logic                                 shock;
  logic                                 take_a;
  logic                                 fan_zero;
  logic signed [31:0]                   pick;
  logic [31:0]                          mag;
  logic signed [34:0]                   lap;
  logic signed [32:0]                   dflux;
  logic signed [PROD_BITS-1:0]          prod;
  logic                                 zero;

  // Exact Riemann flux branch select
  always_comb begin
    pair_sum = $signed({fa[31], fa}) + $signed({fb[31], fb});
    shock    = fa > fb;
    if (shock) begin
      take_a = pair_sum > 33'sd0;
    end else begin
      take_a = !fa[31];
    end
    fan_zero = !shock && fa[31] && (fb > 32'sd0);
    pick     = take_a ? fa : fb;
    mag      = pick[31] ? (32'd0 - pick) : pick;
  end

  always_comb begin
    lap   = $signed({{3{right[31]}}, right}) - $signed({{2{cur[31]}}, cur, 1'b0})
          + $signed({{3{prev_old[31]}}, prev_old});
    dflux = $signed({flux[31], flux}) - $signed({prev_flux[31], prev_flux});
    case (ctrl.op)
      ALU_SQ: begin
        op_a = $signed({3'b000, mag});
        op_b = $signed({1'b0, mag});
      end
      ALU_DIFF: begin
        op_a = lap;
        op_b = $signed({9'd0, diffusion});
      end
      ALU_CONV: begin
        op_a = $signed({{2{dflux[32]}}, dflux});
        op_b = $signed({9'd0, courant});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign mul = op_a * op_b;

  always_ff @(posedge clk) begin
    if (ctrl.op != ALU_NONE) begin
      prod <= mul[PROD_BITS-1:0];
      zero <= (ctrl.op == ALU_SQ) && fan_zero;
    end
  end

  assign stat.prod = prod;
  assign stat.zero = zero;

endmodule

`default_nettype wire

/* hw/rtl/burgers_godunov_stencil_step.sv */
// Top level: periodic 1D viscous Burgers cell row with a Godunov step sequencer.
`default_nettype none

// A row of up to MAX_CELLS signed Q16.16 cells. A write beat loads one cell, a
// read beat returns one, and a step beat advances the cells 0..n-1 (n is
// cell_count clamped to 3..MAX_CELLS) by one Godunov time step with periodic
// wrap: exact Riemann flux of u*u/2 at each interface, Courant-weighted flux
// difference, diffusion term, saturation to the VALUE_BITS range (clamped to
// 16..32). Every input beat yields exactly one output beat; saturated flags a
// clipped flux or cell during a step, index_error an index at or beyond n.
// After reset the block clears the cell memory, one entry a cycle, with
// in_ready low. A write beat goes straight to the result hand-over; a read beat
// with an index below n first waits for the registered read data. A step passes
// each cell through a load, three uses of one shared multiplier (flux square,
// diffusion, convection) and a write-back, over a single read port of the cell
// memory. Before the cells it accepts the beat, reads cell 0 and the last cell
// and forms the wrap-interface flux (square, flux, hand-over as left flux);
// after them it hands the result over. Any item takes longer while the output
// register still holds an unaccepted result.
// in_ready is high only between items; the result register lets the next beat
// enter while the previous result still waits for out_ready.

module burgers_godunov_stencil_step
  import bgs_pkg::*;
#(
  parameter int MAX_CELLS  = DEF_MAX_CELLS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_t             out_data
);

  localparam int AW = $clog2(MAX_CELLS);
  localparam int NW = $clog2(MAX_CELLS + 1);
  localparam int VW = (VALUE_BITS < 16) ? 16 : ((VALUE_BITS > 32) ? 32 : VALUE_BITS);
  localparam logic signed [63:0] VMAX = (64'sd1 <<< (VW - 1)) - 64'sd1;
  localparam logic signed [63:0] VMIN = -VMAX - 64'sd1;

  // Sequencer states
  localparam logic [3:0] ST_CLR  = 4'd0;   // memory clear after reset
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_RD   = 4'd2;   // read data arrives
  localparam logic [3:0] ST_DONE = 4'd3;   // hand result to output register
  localparam logic [3:0] ST_P0   = 4'd4;   // cell 0 arrives
  localparam logic [3:0] ST_P1   = 4'd5;   // last cell arrives
  localparam logic [3:0] ST_SQ   = 4'd6;   // square the chosen flux value
  localparam logic [3:0] ST_FX   = 4'd7;   // flux out, diffusion product in
  localparam logic [3:0] ST_CV   = 4'd8;   // diffusion out, convection product in
  localparam logic [3:0] ST_UP   = 4'd9;   // new cell value written back
  localparam logic [3:0] ST_PF   = 4'd10;  // wrap flux becomes left flux
  localparam logic [3:0] ST_LD   = 4'd11;  // right neighbor arrives

  logic [3:0]  state;
  logic [AW-1:0] i;
  logic        pro;
  logic        clip;

  logic [8:0]  cell_count;
  logic [23:0] courant_ratio;
  logic [23:0] diffusion_number;

  logic signed [31:0] first_old_value;
  logic signed [31:0] prev_old_value;
  logic signed [31:0] prev_flux;
  logic signed [31:0] cur;
  logic signed [31:0] right;
  logic signed [31:0] fa;
  logic signed [31:0] fb;
  logic signed [31:0] flux;
  logic signed [47:0] diff_term;
  out_t               res;

  logic [NW-1:0] n_eff;
  logic [AW-1:0] n_last;
  logic [AW:0]   i_inc;
  logic [AW:0]   i_inc2;
  logic [AW-1:0] next_right;
  logic [AW-1:0] up_addr;
  logic          is_last;
  logic          index_ok;
  logic          accept;
  logic          out_load;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_raw;
  logic signed [31:0] rd_data;

  alu_ctrl_t alu_ctrl;
  alu_stat_t alu_stat;

  logic signed [63:0] wval;
  logic signed [31:0] wsat;
  logic signed [63:0] fx_shift;
  logic signed [31:0] fx_value;
  logic               fx_over;
  logic signed [63:0] up_sum;
  logic signed [31:0] up_value;
  logic               up_over;
  logic signed [63:0] round_prod;

  // Effective cell count, clamped to 3..MAX_CELLS
  always_comb begin
    if (cell_count < 9'd3) begin
      n_eff = NW'(3);
    end else if (32'(cell_count) > 32'(MAX_CELLS)) begin
      n_eff = NW'(MAX_CELLS);
    end else begin
      n_eff = NW'(cell_count);
    end
  end

  assign n_last   = AW'(n_eff - NW'(1));
  assign i_inc    = {1'b0, i} + (AW + 1)'(1);
  assign i_inc2   = {1'b0, i} + (AW + 1)'(2);
  assign is_last  = (i == n_last);
  // Right neighbor of the last cell comes from the saved cell 0, never memory
  assign next_right = is_last ? '0 : i_inc[AW-1:0];
  assign up_addr  = (is_last || (i_inc[AW-1:0] == n_last)) ? '0 : i_inc2[AW-1:0];
  assign index_ok = {{NW{1'b0}}, in_data.cell_index} < {8'd0, n_eff};
  assign accept   = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE);
  assign rd_data  = $signed(rd_raw);
  // Result moves to the output register once that register is free
  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);

  // Write value saturation (no flag on writes)
  always_comb begin
    wval = $signed({{32{in_data.cell_value[31]}}, in_data.cell_value});
    if (wval > VMAX) begin
      wsat = VMAX[31:0];
    end else if (wval < VMIN) begin
      wsat = VMIN[31:0];
    end else begin
      wsat = wval[31:0];
    end
  end

  // Flux from the square: round by 2^17, saturate high
  always_comb begin
    fx_shift = (alu_stat.prod + 64'sd65536) >>> 17;
    fx_over  = 1'b0;
    if (alu_stat.zero) begin
      fx_value = '0;
    end else if (fx_shift > VMAX) begin
      fx_value = VMAX[31:0];
      fx_over  = 1'b1;
    end else begin
      fx_value = fx_shift[31:0];
    end
  end

  // Cell update: u - conv + diff, saturated
  always_comb begin
    round_prod = round_q16(alu_stat.prod);
    up_sum     = $signed({{32{cur[31]}}, cur}) - round_prod
               + $signed({{16{diff_term[47]}}, diff_term});
    up_over    = 1'b0;
    if (up_sum > VMAX) begin
      up_value = VMAX[31:0];
      up_over  = 1'b1;
    end else if (up_sum < VMIN) begin
      up_value = VMIN[31:0];
      up_over  = 1'b1;
    end else begin
      up_value = up_sum[31:0];
    end
  end

  // Memory port and multiplier control
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = i;
    mem_wdata   = '0;
    rd_addr     = next_right;
    alu_ctrl.op = ALU_NONE;
    case (state)
      ST_CLR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        rd_addr = (in_data.func == FUNC_READ) ? AW'(in_data.cell_index) : '0;
        if (accept && (in_data.func == FUNC_WRITE) && index_ok) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(in_data.cell_index);
          mem_wdata = wsat;
        end
      end
      ST_P0: begin
        rd_addr = n_last;
      end
      ST_SQ: begin
        alu_ctrl.op = ALU_SQ;
      end
      ST_FX: begin
        alu_ctrl.op = ALU_DIFF;
      end
      ST_CV: begin
        alu_ctrl.op = ALU_CONV;
      end
      ST_UP: begin
        mem_we    = 1'b1;
        mem_wdata = up_value;
        rd_addr   = up_addr;
      end
      default: begin
      end
    endcase
  end

  bgs_cell_ram #(
    .DEPTH (MAX_CELLS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_addr),
    .rdata (rd_raw)
  );

  bgs_alu u_alu (
    .clk       (clk),
    .ctrl      (alu_ctrl),
    .fa        (fa),
    .fb        (fb),
    .cur       (cur),
    .right     (right),
    .prev_old  (prev_old_value),
    .flux      (flux),
    .prev_flux (prev_flux),
    .courant   (courant_ratio),
    .diffusion (diffusion_number),
    .stat      (alu_stat)
  );

  // Config registers; to be written only between items (the block does not enforce it)
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_count       <= RST_CELL_COUNT;
      courant_ratio    <= RST_COURANT;
      diffusion_number <= RST_DIFFUSION;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_CELL_COUNT: cell_count       <= cfg_data[8:0];
        CFG_COURANT:    courant_ratio    <= cfg_data;
        CFG_DIFFUSION:  diffusion_number <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_data  <= res;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      i         <= '0;
      pro       <= 1'b0;
      clip      <= 1'b0;
    end else begin
      case (state)
        ST_CLR: begin
          if (32'(i) == 32'(MAX_CELLS - 1)) begin
            i     <= '0;
            state <= ST_IDLE;
          end else begin
            i <= i_inc[AW-1:0];
          end
        end
        ST_IDLE: begin
          if (accept) begin
            case (in_data.func)
              FUNC_WRITE: begin
                res   <= '{read_value: '0, index_error: !index_ok, saturated: 1'b0};
                state <= ST_DONE;
              end
              FUNC_READ: begin
                res   <= '{read_value: '0, index_error: !index_ok, saturated: 1'b0};
                state <= index_ok ? ST_RD : ST_DONE;
              end
              FUNC_STEP: begin
                clip  <= 1'b0;
                i     <= '0;
                state <= ST_P0;
              end
              default: begin
                res   <= '0;
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_RD: begin
          res.read_value <= rd_data;
          state          <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        ST_P0: begin
          first_old_value <= rd_data;
          cur             <= rd_data;
          state           <= ST_P1;
        end
        ST_P1: begin
          // wrap interface: last cell against cell 0
          prev_old_value <= rd_data;
          fa             <= rd_data;
          fb             <= first_old_value;
          pro            <= 1'b1;
          state          <= ST_SQ;
        end
        ST_SQ: begin
          state <= ST_FX;
        end
        ST_FX: begin
          flux  <= fx_value;
          clip  <= clip || fx_over;
          state <= pro ? ST_PF : ST_CV;
        end
        ST_PF: begin
          prev_flux <= flux;
          pro       <= 1'b0;
          state     <= ST_LD;
        end
        ST_LD: begin
          // last cell recomputes the wrap flux from the same old values
          right <= is_last ? first_old_value : rd_data;
          fa    <= cur;
          fb    <= is_last ? first_old_value : rd_data;
          state <= ST_SQ;
        end
        ST_CV: begin
          diff_term <= round_prod[47:0];
          state     <= ST_UP;
        end
        ST_UP: begin
          prev_old_value <= cur;
          prev_flux      <= flux;
          cur            <= right;
          clip           <= clip || up_over;
          if (is_last) begin
            res   <= '{read_value: '0, index_error: 1'b0, saturated: clip || up_over};
            i     <= '0;
            state <= ST_DONE;
          end else begin
            i     <= i_inc[AW-1:0];
            state <= ST_LD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Write-back never runs past the last active cell
  a_up_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UP) |-> (i <= n_last))
    else $error("step write-back beyond last active cell");

  // A step beat holds off the input channel on the next cycle
  a_step_blocks: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_data.func == FUNC_STEP)) |=> !in_ready)
    else $error("input accepted during a step");

  // Fluxes of u*u/2 are never negative
  a_flux_nonneg: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_CV) || (state == ST_PF)) |-> !flux[31])
    else $error("negative interface flux");

endmodule

`default_nettype wire
